@@ rtl/bsli_pkg.sv @@
// shared types and constants for the bounded stack with lazy increment
`default_nettype none
package bsli_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_INC  = 2'd2;

  // fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;

  // reset value of the size limit register
  localparam logic [COUNT_W-1:0] MAX_SIZE_RST = 11'd1024;

  // value returned by a pop of an empty stack
  localparam logic [VALUE_W-1:0] POP_EMPTY_VALUE = 32'hFFFF_FFFF;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input beat and launch the memory read
    logic exec;   // finish the operation: write back, update depth, emit result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_pop;    // captured operation produces a result beat
    logic out_busy;  // result register is full and stalled
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/bounded_stack_lazy_increment_unit.sv @@
// top level of the bounded stack with lazy add-to-bottom-k increment
// usage:
//   input channel (in_valid/in_stall) carries one operation per beat:
//   push in_push_value, pop, or add in_add_amount to the bottom in_add_count
//   entries. only a pop produces a result beat on the out channel
//   (out_valid/out_stall): the top word plus its pending add, or all ones
//   with out_was_empty set when the stack was empty.
//   cfg_valid/cfg_ready writes the max_size limit; cfg_ready is always high.
// timing:
//   each operation first captures the beat and reads the {entry, pending
//   add} memory, then writes back the modified row. the result of a pop
//   is registered in the result register when its write back executes.
//   a new beat is taken only after the current operation has written
//   back, as the synchronous memory is read and then written.
// reset and stall:
//   reset empties the stack and sets max_size to 1024; no clearing pass is
//   needed since a push zeroes the pending add of the slot it fills.
//   while a result waits under out_stall the next input beat is still taken;
//   only a second pop is held until the result register frees up.
`default_nettype none
module bounded_stack_lazy_increment_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_opcode,
  input  wire logic signed [bsli_pkg::VALUE_W-1:0] in_push_value,
  input  wire logic [bsli_pkg::COUNT_W-1:0]        in_add_count,
  input  wire logic signed [bsli_pkg::VALUE_W-1:0] in_add_amount,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [bsli_pkg::VALUE_W-1:0]      out_popped_value,
  output logic                                     out_was_empty,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bsli_pkg::COUNT_W-1:0]        cfg_max_size
);

  bsli_pkg::cmd_t  cmd;
  bsli_pkg::stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  bsli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsli_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .in_add_count     (in_add_count),
    .in_add_amount    (in_add_amount),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_max_size     (cfg_max_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_was_empty    (out_was_empty)
  );

  // an accepted beat holds the input off while it executes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after an accepted beat");

  // a new result only follows an execute cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an executing operation");

  // an empty pop always carries all ones
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_empty) |-> (out_popped_value == bsli_pkg::POP_EMPTY_VALUE))
    else $error("empty pop result is not all ones");

  // execute and load never coincide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and execute issued together");

endmodule
`default_nettype wire

@@ rtl/bsli_ram.sv @@
// generic simple dual port ram, one write port and two registered read ports
`default_nettype none
module bsli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                             rdata_a,
  output logic      [WIDTH-1:0]                             rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bsli_ctrl.sv @@
// controller state machine: capture a beat, then execute it
`default_nettype none
module bsli_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bsli_pkg::stat_t stat,
  output bsli_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a pop waits until the result register can take its beat
        if (!(stat.op_pop && stat.out_busy)) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bsli_dpath.sv @@
// datapath: depth counter, size limit, entry/pending-add memory, result register
`default_nettype none
module bsli_dpath #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bsli_pkg::cmd_t               cmd,
  output bsli_pkg::stat_t                   stat,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic signed [bsli_pkg::VALUE_W-1:0] in_push_value,
  input  wire logic [bsli_pkg::COUNT_W-1:0] in_add_count,
  input  wire logic signed [bsli_pkg::VALUE_W-1:0] in_add_amount,
  input  wire logic                         cfg_we,
  input  wire logic [bsli_pkg::COUNT_W-1:0] cfg_max_size,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [bsli_pkg::VALUE_W-1:0] out_popped_value,
  output logic                              out_was_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (DW > bsli_pkg::COUNT_W) ? DW : bsli_pkg::COUNT_W;
  localparam int unsigned XW = (DATA_WIDTH > bsli_pkg::VALUE_W) ? DATA_WIDTH
                                                                : bsli_pkg::VALUE_W;
  localparam int unsigned RW = 2 * DATA_WIDTH;

  logic [DW-1:0]                   depth_r;
  logic [bsli_pkg::COUNT_W-1:0]    max_size_r;
  logic [1:0]                      op_r;
  logic [DATA_WIDTH-1:0]           word_r;
  logic                            go_r;
  logic                            below_r;
  logic [AW-1:0]                   waddr_r;
  logic                            out_valid_r;
  logic [bsli_pkg::VALUE_W-1:0]    out_value_r;
  logic                            out_empty_r;

  logic [CW-1:0]         depth_x;
  logic [CW-1:0]         max_x;
  logic [CW-1:0]         cnt_x;
  logic [CW-1:0]         lim_x;
  logic [CW-1:0]         lim_m1;
  logic [CW-1:0]         top_m1;
  logic [CW-1:0]         top_m2;
  logic                  push_ok;
  logic signed [XW-1:0]  push_x;
  logic signed [XW-1:0]  amt_x;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic                  go_nxt;
  logic                  below_nxt;
  logic [AW-1:0]         waddr_nxt;
  logic [DATA_WIDTH-1:0] word_nxt;

  logic                  we;
  logic [RW-1:0]         wdata;
  logic [RW-1:0]         rdata_a;
  logic [RW-1:0]         rdata_b;
  logic [DATA_WIDTH-1:0] ent_a;
  logic [DATA_WIDTH-1:0] pend_a;
  logic [DATA_WIDTH-1:0] ent_b;
  logic [DATA_WIDTH-1:0] pend_b;
  logic [DATA_WIDTH-1:0] pop_sum;
  logic [XW-1:0]         pop_sum_x;

  // address and limit arithmetic for the incoming beat
  always_comb begin
    depth_x = CW'(depth_r);
    max_x   = CW'(max_size_r);
    cnt_x   = CW'(in_add_count);
    lim_x   = (cnt_x < depth_x) ? cnt_x : depth_x;
    lim_m1  = lim_x - CW'(1);
    top_m1  = depth_x - CW'(1);
    top_m2  = depth_x - CW'(2);
    push_ok = (depth_x < max_x) && (depth_r < DW'(DEPTH));
    push_x  = XW'(in_push_value);
    amt_x   = XW'(in_add_amount);
    raddr_a = (in_opcode == bsli_pkg::OP_INC) ? lim_m1[AW-1:0] : top_m1[AW-1:0];
    raddr_b = top_m2[AW-1:0];
  end

  // decode of the incoming beat
  always_comb begin
    go_nxt    = 1'b0;
    below_nxt = 1'b0;
    waddr_nxt = top_m2[AW-1:0];
    word_nxt  = amt_x[DATA_WIDTH-1:0];
    unique case (in_opcode)
      bsli_pkg::OP_PUSH: begin
        go_nxt    = push_ok;
        waddr_nxt = depth_x[AW-1:0];
        word_nxt  = push_x[DATA_WIDTH-1:0];
      end
      bsli_pkg::OP_POP: begin
        go_nxt    = (depth_r != '0);
        below_nxt = (depth_x > CW'(1));
      end
      bsli_pkg::OP_INC: begin
        go_nxt    = (lim_x != '0);
        waddr_nxt = lim_m1[AW-1:0];
      end
      default: begin
        go_nxt = 1'b0;
      end
    endcase
  end

  // captured beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      word_r  <= word_nxt;
      go_r    <= go_nxt;
      below_r <= below_nxt;
      waddr_r <= waddr_nxt;
    end
  end

  // memory rows hold {entry, pending add}
  always_comb begin
    ent_a     = rdata_a[RW-1:DATA_WIDTH];
    pend_a    = rdata_a[DATA_WIDTH-1:0];
    ent_b     = rdata_b[RW-1:DATA_WIDTH];
    pend_b    = rdata_b[DATA_WIDTH-1:0];
    pop_sum   = ent_a + pend_a;
    pop_sum_x = XW'(pop_sum);
  end

  // write back: push clears the pending add of its slot, pop hands its add down
  always_comb begin
    we    = 1'b0;
    wdata = {ent_a, pend_a + word_r};
    case (op_r)
      bsli_pkg::OP_PUSH: begin
        we    = cmd.exec && go_r;
        wdata = {word_r, {DATA_WIDTH{1'b0}}};
      end
      bsli_pkg::OP_INC: begin
        we    = cmd.exec && go_r;
        wdata = {ent_a, pend_a + word_r};
      end
      bsli_pkg::OP_POP: begin
        we    = cmd.exec && go_r && below_r;
        wdata = {ent_b, pend_b + pend_a};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bsli_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr_r),
    .wdata   (wdata),
    .re      (cmd.load),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // depth counter and size limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      max_size_r <= bsli_pkg::MAX_SIZE_RST;
    end else begin
      if (cfg_we) begin
        max_size_r <= cfg_max_size;
      end
      if (cmd.exec && go_r && (op_r == bsli_pkg::OP_PUSH)) begin
        depth_r <= depth_r + DW'(1);
      end else if (cmd.exec && go_r && (op_r == bsli_pkg::OP_POP)) begin
        depth_r <= depth_r - DW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec && (op_r == bsli_pkg::OP_POP)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == bsli_pkg::OP_POP)) begin
      out_value_r <= go_r ? pop_sum_x[bsli_pkg::VALUE_W-1:0] : bsli_pkg::POP_EMPTY_VALUE;
      out_empty_r <= !go_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_was_empty    = out_empty_r;

  // status toward the controller
  assign stat.op_pop   = (op_r == bsli_pkg::OP_POP);
  assign stat.out_busy = out_valid_r && out_stall;

endmodule
`default_nettype wire
